FILE: sv/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned LEN_W       = 61;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LEN_SLOT     = 6'd56;

    typedef logic [31:0] word_t;

    // Block kinds handed from the front to the back.
    typedef enum logic [1:0] {
        BLK_DATA  = 2'd0,   // full message block, hash continues
        BLK_FINAL = 2'd1,   // last block of a message, digest follows
        BLK_MID   = 2'd2    // data or padding block before the final one
    } blk_kind_t;

    typedef struct packed {
        logic [511:0] data;
        blk_kind_t    kind;
        logic         overflow;
    } blk_t;

    typedef enum logic [1:0] {
        FE_COLLECT = 2'd0,
        FE_PAD2    = 2'd1
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE  = 2'd0,
        BE_ROUND = 2'd1,
        BE_ADD   = 2'd2,
        BE_EMIT  = 2'd3
    } be_state_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror(input word_t v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t sig0(input word_t v);
        return ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t sig1(input word_t v);
        return ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

endpackage

FILE: sv/sha_stream_if.sv
// Valid/ready channel interfaces for byte input and digest word output.
// Uses plain logic vectors; no dependencies.
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
    logic        length_overflow;
    modport source (output valid, digest_word, word_index, final_word, length_overflow,
                    input ready);
    modport sink   (input valid, digest_word, word_index, final_word, length_overflow,
                    output ready);
endinterface

FILE: sv/sha_front.sv
// Byte intake: gathers bytes into a block, counts length, applies padding.
// Depends on sha_pkg; hands finished blocks to the block queue.
`timescale 1ns / 1ps
module sha_front
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink in_ch,
    output logic blk_valid,
    input  logic blk_ready,
    output blk_t blk
);

    fe_state_t        state_reg, state_next;
    logic [511:0]     buf_reg, buf_next;
    logic [5:0]       fill_reg, fill_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic [63:0]      bits_reg, bits_next;

    logic             take;
    logic [6:0]       pos;
    logic [511:0]     work;
    logic [LEN_W-1:0] len_new;
    logic             ovf_new;
    logic [63:0]      bitlen;

    // Byte i of the block sits at bits 511-8i downward.
    function automatic logic [511:0] put_byte(input logic [511:0] b, input logic [5:0] i,
                                              input logic [7:0] v);
        logic [511:0] r;
        r = b;
        r[511 - 8*i -: 8] = v;
        return r;
    endfunction

    // Clear every byte at position i and above.
    function automatic logic [511:0] clear_from(input logic [511:0] b, input logic [6:0] i);
        logic [511:0] mask;
        if (i >= 7'd64) mask = '1;
        else if (i == 7'd0) mask = '0;
        else mask = ~({512{1'b1}} >> (10'(i) * 10'd8));
        return b & mask;
    endfunction

    always_comb
    begin
        take    = in_ch.valid && in_ch.ready;
        len_new = len_reg;
        ovf_new = ovf_reg;
        if (in_ch.byte_valid)
        begin
            if (len_reg == LEN_MAX) ovf_new = 1'b1;
            else len_new = len_reg + 1'b1;
        end
        bitlen = {len_new, 3'b000};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FE_COLLECT:
                if (take && in_ch.end_of_message)
                begin
                    // Pad byte lands past slot 55, or in a new block, when no room is left for the length.
                    if ((in_ch.byte_valid ? 7'(fill_reg) + 7'd1 : 7'(fill_reg)) >= 7'd56)
                        state_next = FE_PAD2;
                end
            FE_PAD2:
                if (blk_ready) state_next = FE_COLLECT;
            default: state_next = FE_COLLECT;
        endcase
    end

    always_comb
    begin
        in_ch.ready = (state_reg == FE_COLLECT) && blk_ready;
        blk_valid   = 1'b0;
        blk         = '{data: buf_reg, kind: BLK_DATA, overflow: ovf_reg};
        buf_next    = buf_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        bits_next   = bits_reg;
        pos         = 7'(fill_reg);
        work        = buf_reg;
        unique case (state_reg)
            FE_COLLECT:
                if (take)
                begin
                    if (in_ch.byte_valid)
                    begin
                        work = put_byte(work, fill_reg, in_ch.data_byte);
                        pos  = 7'(fill_reg) + 7'd1;
                    end
                    len_next  = len_new;
                    ovf_next  = ovf_new;
                    buf_next  = work;
                    fill_next = pos[5:0];
                    if (in_ch.end_of_message)
                    begin
                        if (pos == 7'd64)
                        begin
                            // Full data block first; padding follows in its own block.
                            blk_valid = 1'b1;
                            blk = '{data: work, kind: BLK_MID, overflow: ovf_new};
                            bits_next = bitlen;
                            buf_next  = {PAD_BYTE, 504'd0};
                        end
                        else
                        begin
                            work = put_byte(work, pos[5:0], PAD_BYTE);
                            work = clear_from(work, pos + 7'd1);
                            if (pos + 7'd1 > 7'(LEN_SLOT))
                            begin
                                blk_valid = 1'b1;
                                blk = '{data: work, kind: BLK_MID, overflow: ovf_new};
                                bits_next = bitlen;
                                buf_next  = '0;
                            end
                            else
                            begin
                                work[63:0] = bitlen;
                                blk_valid = 1'b1;
                                blk = '{data: work, kind: BLK_FINAL, overflow: ovf_new};
                                len_next = '0;
                                ovf_next = 1'b0;
                            end
                        end
                        fill_next = '0;
                    end
                    else if (pos == 7'd64)
                    begin
                        blk_valid = 1'b1;
                        blk = '{data: work, kind: BLK_DATA, overflow: ovf_new};
                    end
                end
            FE_PAD2:
            begin
                blk_valid = 1'b1;
                blk = '{data: {buf_reg[511:64], bits_reg}, kind: BLK_FINAL, overflow: ovf_reg};
                if (blk_ready)
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_COLLECT;
            fill_reg  <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        bits_reg <= bits_next;
    end

endmodule

FILE: sv/sha_queue.sv
// Two-entry block queue between the intake and the compression engine.
// Depends on sha_pkg for the block record.
`timescale 1ns / 1ps
module sha_queue
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  blk_t wr_blk,
    output logic rd_valid,
    input  logic rd_ready,
    output blk_t rd_blk
);

    blk_t       mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_blk   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wp_reg] <= wr_blk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: sv/sha_core.sv
// Compression engine: one round per cycle, then the digest word run after a final block.
// Depends on sha_pkg; reads blocks from the queue and drives the output channel.
`timescale 1ns / 1ps
module sha_core
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic blk_valid,
    output logic blk_ready,
    input  blk_t blk,
    sha_out_if.source out_ch
);

    be_state_t  state_reg, state_next;
    word_t      h_reg [8];
    word_t      v_reg [8];
    word_t      w_reg [16];
    logic [5:0] rnd_reg;
    logic [2:0] idx_reg;
    blk_kind_t  kind_reg;
    logic       ovf_reg;

    word_t t1, t2, wnew, e, a;

    always_comb
    begin
        e    = v_reg[4];
        a    = v_reg[0];
        t1   = v_reg[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) +
               ((e & v_reg[5]) ^ (~e & v_reg[6])) + ROUND_K[rnd_reg] + w_reg[0];
        t2   = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) +
               ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        wnew = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE:  if (blk_valid) state_next = BE_ROUND;
            BE_ROUND: if (rnd_reg == 6'(ROUNDS - 1)) state_next = BE_ADD;
            BE_ADD:   state_next = (kind_reg == BLK_FINAL) ? BE_EMIT : BE_IDLE;
            BE_EMIT:  if (out_ch.ready && idx_reg == 3'd7) state_next = BE_IDLE;
            default:  state_next = BE_IDLE;
        endcase
    end

    always_comb
    begin
        blk_ready              = (state_reg == BE_IDLE);
        out_ch.valid           = (state_reg == BE_EMIT);
        out_ch.digest_word     = h_reg[idx_reg];
        out_ch.word_index      = idx_reg;
        out_ch.final_word      = (idx_reg == 3'd7);
        out_ch.length_overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            h_reg     <= INIT_H;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                BE_IDLE:  rnd_reg <= '0;
                BE_ROUND: rnd_reg <= rnd_reg + 6'd1;
                BE_ADD:
                begin
                    idx_reg <= '0;
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                end
                BE_EMIT:
                    if (out_ch.ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) h_reg <= INIT_H;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BE_IDLE && blk_valid)
        begin
            for (int i = 0; i < 16; i++) w_reg[i] <= blk.data[511 - 32*i -: 32];
            v_reg    <= h_reg;
            kind_reg <= blk.kind;
            ovf_reg  <= blk.overflow;
        end
        else if (state_reg == BE_ROUND)
        begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

FILE: sv/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher top level: intake, block queue, compression engine.
// Throughput: one byte item per cycle while the queue has room and no padding block
// waits; each block runs through the round engine (load, 64 rounds, add), which sets
// the sustained rate. After the closing item the final block goes through the engine,
// behind an extra block when the padding spills over; then eight words follow.
// Reset (rst_n, asynchronous, active low) loads the initial hash and empties the queue.
`timescale 1ns / 1ps
module sha256_stream_hasher_unit
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    // The front packs bytes and padding into whole blocks; the queue lets byte intake
    // continue while the engine runs its rounds on an earlier block.
    logic fq_valid, fq_ready, qc_valid, qc_ready;
    blk_t fq_blk, qc_blk;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .blk_valid (fq_valid),
        .blk_ready (fq_ready),
        .blk       (fq_blk)
    );

    sha_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_blk   (fq_blk),
        .rd_valid (qc_valid),
        .rd_ready (qc_ready),
        .rd_blk   (qc_blk)
    );

    // The engine emits the eight digest words in order once a final block is done.
    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (qc_valid),
        .blk_ready (qc_ready),
        .blk       (qc_blk),
        .out_ch    (out_ch)
    );

    // Words of a digest come in order: each accepted word follows the previous index.
    property p_index_order;
        @(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.final_word) |=>
            (out_ch.word_index == $past(out_ch.word_index) + 3'd1);
    endproperty
    a_index_order: assert property (p_index_order) else $error("digest word order broken");

    // Final flag only on the last word.
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.final_word == (out_ch.word_index == 3'd7)))
        else $error("final_word flag misplaced");

    // Intake never offers a block the queue refuses without holding it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fq_valid && !fq_ready) |-> !(in_ch.valid && in_ch.ready))
        else $error("item accepted while queue full");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the SHA-256 stream hasher unit.
// Depends on sha_pkg, the sha_in_if/sha_out_if channel interfaces and the unit itself.
`timescale 1ns / 1ps
module tb_top;
    import sha_pkg::*;

    // One input item as the sender sees it. pause_after makes the sender
    // wait, once this item is taken, until every expected digest word is out.
    typedef struct {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
        bit         pause_after;
    } byte_item_t;

    typedef struct {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       final_word;
        logic       length_overflow;
    } digest_out_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   error_count;
    bit   calm_window;

    byte_item_t  pending_items[$];
    digest_out_t expected_words[$];

    // Software copy of the hashing state.
    word_t       sha_h[8];
    logic [7:0]  sha_block[64];
    int          sha_fill;
    longint      sha_msg_len;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Every input gets a known value from time zero; reset is held low at the start, then released.
    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.byte_valid = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial cycle_count = 0;

    function automatic word_t rotr(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of the collected block into sha_h.
    task automatic compress_block();
        word_t w[64];
        word_t v[8];
        word_t t1;
        word_t t2;
        word_t s0;
        word_t s1;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = sha_h;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            sha_h[i] = sha_h[i] + v[i];
        end
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            sha_h[i] = INIT_H[i];
        end
        sha_fill = 0;
        sha_msg_len = 0;
    endtask

    // Absorb one accepted item and queue the digest words it produces.
    // Messages here are far too short to reach the length limit, so the
    // overflow flag is always expected low.
    task automatic hash_accepted_item(input logic [7:0] b, input logic bv, input logic eom);
        logic [63:0] bit_len;
        digest_out_t d;
        if (bv)
        begin
            sha_msg_len++;
            sha_block[sha_fill] = b;
            sha_fill = (sha_fill + 1) % 64;
            if (sha_fill == 0)
            begin
                compress_block();
            end
        end
        if (eom)
        begin
            sha_block[sha_fill] = PAD_BYTE;
            sha_fill++;
            // The length field does not fit behind the pad, so an extra block goes first.
            if (sha_fill > 56)
            begin
                for (int i = sha_fill; i < 64; i++)
                begin
                    sha_block[i] = 8'h00;
                end
                compress_block();
                sha_fill = 0;
            end
            for (int i = sha_fill; i < 56; i++)
            begin
                sha_block[i] = 8'h00;
            end
            bit_len = sha_msg_len << 3;
            for (int i = 0; i < 8; i++)
            begin
                sha_block[56+i] = bit_len[63-8*i -: 8];
            end
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.digest_word = sha_h[i];
                d.word_index = i[2:0];
                d.final_word = (i == 7);
                d.length_overflow = 1'b0;
                expected_words.push_back(d);
            end
            restart_hash();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic bit take_a_break();
        return !calm_window && ($urandom_range(99) < 33);
    endfunction

    // Sender. The item on the bus is absorbed into the prediction when it is
    // taken, and a new one is picked only when the bus is free.
    bit hold_for_digest;
    always @(posedge clk)
    begin
        byte_item_t it;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                hash_accepted_item(in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message);
            end
            // The pause ends only once the marked item is taken and its words are out.
            if (hold_for_digest && !(in_ch.valid && !in_ch.ready) &&
                expected_words.size() == 0)
            begin
                hold_for_digest = 1'b0;
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (!hold_for_digest && pending_items.size() != 0 && !take_a_break())
                begin
                    it = pending_items.pop_front();
                    in_ch.data_byte <= it.data_byte;
                    in_ch.byte_valid <= it.byte_valid;
                    in_ch.end_of_message <= it.end_of_message;
                    in_ch.valid <= 1'b1;
                    hold_for_digest = it.pause_after;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure and a field-by-field check of every word.
    always @(posedge clk)
    begin
        digest_out_t exp_w;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected digest word %h", out_ch.digest_word));
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_ch.digest_word !== exp_w.digest_word)
                    begin
                        report_mismatch($sformatf("digest_word %h, want %h",
                                                  out_ch.digest_word, exp_w.digest_word));
                    end
                    if (out_ch.word_index !== exp_w.word_index)
                    begin
                        report_mismatch($sformatf("word_index %0d, want %0d",
                                                  out_ch.word_index, exp_w.word_index));
                    end
                    if (out_ch.final_word !== exp_w.final_word)
                    begin
                        report_mismatch($sformatf("final_word %b, want %b",
                                                  out_ch.final_word, exp_w.final_word));
                    end
                    if (out_ch.length_overflow !== exp_w.length_overflow)
                    begin
                        report_mismatch($sformatf("length_overflow %b, want %b",
                                                  out_ch.length_overflow,
                                                  exp_w.length_overflow));
                    end
                end
            end
            out_ch.ready <= !take_a_break();
        end
    end

    task automatic add_item(input logic [7:0] b, input logic bv, input logic eom,
                            input bit pause = 1'b0);
        byte_item_t it;
        it.data_byte = b;
        it.byte_valid = bv;
        it.end_of_message = eom;
        it.pause_after = pause;
        pending_items.push_back(it);
    endtask

    // A message of n bytes from the given source; it closes either on the
    // last byte or with a separate empty item.
    task automatic add_message(input int n, input int fill_mode, input bit separate_end);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            case (fill_mode)
                0: b = 8'($urandom_range(255));
                1: b = 8'hff;
                2: b = 8'h00;
                default: b = 8'(8'h61 + i % 26);
            endcase
            // Noise items that carry nothing are mixed in now and then.
            if ($urandom_range(19) == 0)
            begin
                add_item(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            add_item(b, 1'b1, !separate_end && i == n - 1);
        end
        if (separate_end || n == 0)
        begin
            add_item(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        int n;
        error_count = 0;
        calm_window = 1'b0;
        hold_for_digest = 1'b0;
        restart_hash();

        // Directed part: empty message, items that carry nothing, "abc",
        // extreme byte values, and lengths around the padding boundary.
        add_item(8'hff, 1'b0, 1'b1);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_message(3, 3, 1'b0);
        add_message(1, 1, 1'b0);
        add_message(1, 2, 1'b1);
        add_message(55, 0, 1'b0);
        add_message(56, 1, 1'b0);
        add_message(64, 0, 1'b1);
        pending_items[pending_items.size() - 1].pause_after = 1'b1;

        // Random messages, mostly short, a few spanning several blocks.
        while (pending_items.size() < 410)
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(200) : $urandom_range(70);
            add_message(n, ($urandom_range(9) == 0) ? $urandom_range(2) + 1 : 0,
                        1'($urandom_range(1)));
        end

        // A stretch with no idling on either side while traffic is still flowing.
        wait (rst_n);
        repeat (200) @(posedge clk);
        calm_window = 1'b1;
        repeat (1200) @(posedge clk);
        calm_window = 1'b0;

        wait (pending_items.size() == 0 && !in_ch.valid && expected_words.size() == 0);
        repeat (300) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/sha_pkg.sv
sv/sha_stream_if.sv
sv/sha_front.sv
sv/sha_queue.sv
sv/sha_core.sv
sv/sha256_stream_hasher_unit.sv
dv/tb_top.sv
